[rtl/ordered_list_engine_macros.svh]
// Assertion macros used by ordered_list_engine.sv.
`ifndef ORDERED_LIST_ENGINE_MACROS_SVH
`define ORDERED_LIST_ENGINE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, held off in reset
`define OLE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define OLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/ole_pkg.sv]
`default_nettype none

package ole_pkg;

  // Default number of cells in the chain
  localparam int DEFAULT_LIST_DEPTH = 16;

  // Fixed field widths
  localparam int MODE_W   = 3;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 5;
  localparam int STATUS_W = 3;

  // Operation codes
  typedef enum logic [MODE_W-1:0] {
    MODE_INS_FRONT = 3'd0,
    MODE_INS_BACK  = 3'd1,
    MODE_INS_POS   = 3'd2,
    MODE_DEL_FRONT = 3'd3,
    MODE_DEL_BACK  = 3'd4,
    MODE_DEL_POS   = 3'd5,
    MODE_LIST      = 3'd6,
    MODE_SEARCH    = 3'd7
  } mode_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 3'd0,
    STAT_EMPTY    = 3'd1,
    STAT_BADPOS   = 3'd2,
    STAT_NOTFOUND = 3'd3,
    STAT_FULL     = 3'd4
  } status_t;

  // Controller states
  typedef enum logic {
    S_IDLE = 1'b0,
    S_LIST = 1'b1
  } state_t;

  // Command broadcast to every cell of the chain
  typedef struct packed {
    logic              ins;    // open a slot at the index, later cells move up
    logic              del;    // close the slot at the index, later cells move down
    logic [DATA_W-1:0] value;  // value written into the opened slot
  } cell_cmd_t;

endpackage

`default_nettype wire

[rtl/ole_cell.sv]
`default_nettype none

module ole_cell #(
  parameter int CELL_IDX = 0,
  parameter int IDX_W    = 4
) (
  input  wire                         clk,
  input  wire  ole_pkg::cell_cmd_t    cmd,
  input  wire  [IDX_W-1:0]            idx,
  input  wire  [ole_pkg::DATA_W-1:0]  prev_data,
  input  wire  [ole_pkg::DATA_W-1:0]  next_data,
  input  wire  [ole_pkg::DATA_W-1:0]  key,
  output logic [ole_pkg::DATA_W-1:0]  data,
  output logic                        match
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic [ole_pkg::DATA_W-1:0] data_r;
  logic [ole_pkg::DATA_W-1:0] data_nxt;

  // Slot update: load, take from lower neighbour, take from upper neighbour
  always_comb begin
    data_nxt = data_r;
    if (cmd.ins) begin
      if (idx == MY_IDX) begin
        data_nxt = cmd.value;
      end else if (idx < MY_IDX) begin
        data_nxt = prev_data;
      end
    end else if (cmd.del) begin
      if (idx <= MY_IDX) begin
        data_nxt = next_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data  = data_r;
  assign match = (data_r == key);

endmodule

`default_nettype wire

[rtl/ordered_list_engine.sv]
// Channel   | Ports                                                   | Direction
// ----------+---------------------------------------------------------+----------
// in_       | in_valid, in_ready, in_mode, in_value, in_position,     | input
//           | in_search_key                                           |
// out_      | out_valid, out_ready, out_status, out_value,            | output
//           | out_found_position, out_last                            |
//
// Insert, delete and search each complete on acceptance: every cell shifts or
// compares in parallel, and the result lands in the output register.
// A list of N entries gives N transactions, one per cycle while out_ready is
// high; no input is taken until the last of them is in the output register.
// A new transaction is taken while a result waits, once out_ready frees it.
// Synchronous reset empties the list; entry values are not cleared.
`default_nettype none

`include "ordered_list_engine_macros.svh"

module ordered_list_engine #(
  parameter int LIST_DEPTH = ole_pkg::DEFAULT_LIST_DEPTH
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           in_valid,
  output logic                          in_ready,
  input  wire  [ole_pkg::MODE_W-1:0]    in_mode,
  input  wire  [ole_pkg::DATA_W-1:0]    in_value,
  input  wire  [ole_pkg::POS_W-1:0]     in_position,
  input  wire  [ole_pkg::DATA_W-1:0]    in_search_key,
  output logic                          out_valid,
  input  wire                           out_ready,
  output logic [ole_pkg::STATUS_W-1:0]  out_status,
  output logic [ole_pkg::DATA_W-1:0]    out_value,
  output logic [ole_pkg::POS_W-1:0]     out_found_position,
  output logic                          out_last
);

  localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CNT_W = $clog2(LIST_DEPTH + 1);
  localparam int PW    = ((CNT_W > ole_pkg::POS_W) ? CNT_W : ole_pkg::POS_W) + 1;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(LIST_DEPTH);

  // Control state
  ole_pkg::state_t   state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [IDX_W-1:0]  list_idx_r, list_idx_nxt;

  // Output register
  logic                          out_valid_r, out_valid_nxt;
  ole_pkg::status_t              out_status_r, out_status_nxt;
  logic [ole_pkg::DATA_W-1:0]    out_value_r, out_value_nxt;
  logic [ole_pkg::POS_W-1:0]     out_fpos_r, out_fpos_nxt;
  logic                          out_last_r, out_last_nxt;

  // Chain signals
  ole_pkg::cell_cmd_t            cmd;
  logic [IDX_W-1:0]              op_idx;
  logic [IDX_W-1:0]              rd_idx;
  logic [ole_pkg::DATA_W-1:0]    cell_data [LIST_DEPTH];
  logic [LIST_DEPTH-1:0]         cell_match;

  // Decode results
  logic                          out_free;
  logic                          in_acc;
  logic                          is_full, is_empty;
  logic [PW-1:0]                 pos_e, cnt_e;
  ole_pkg::status_t              dec_status;
  logic [ole_pkg::DATA_W-1:0]    dec_value;
  logic [ole_pkg::POS_W-1:0]     dec_fpos;
  logic                          dec_last;
  logic                          dec_list;
  logic                          found;
  logic [ole_pkg::POS_W-1:0]     found_pos;
  logic                          list_end;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ole_pkg::S_IDLE) && out_free;
  assign in_acc   = in_valid && in_ready;
  assign is_full  = (count_r == FULL_CNT);
  assign is_empty = (count_r == '0);
  assign pos_e    = PW'(in_position);
  assign cnt_e    = PW'(count_r);
  assign list_end = ((CNT_W'(list_idx_r) + CNT_W'(1)) == count_r);

  // Cell chain
  for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
    logic [ole_pkg::DATA_W-1:0] prev_d, next_d;
    if (g == 0) begin : g_first
      assign prev_d = '0;
    end else begin : g_mid_lo
      assign prev_d = cell_data[g-1];
    end
    if (g == LIST_DEPTH - 1) begin : g_last
      assign next_d = '0;
    end else begin : g_mid_hi
      assign next_d = cell_data[g+1];
    end
    ole_cell #(
      .CELL_IDX (g),
      .IDX_W    (IDX_W)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .idx       (op_idx),
      .prev_data (prev_d),
      .next_data (next_d),
      .key       (in_search_key),
      .data      (cell_data[g]),
      .match     (cell_match[g])
    );
  end

  // First live match, lowest position wins
  always_comb begin
    found     = 1'b0;
    found_pos = '0;
    for (int i = LIST_DEPTH - 1; i >= 0; i--) begin
      if (cell_match[i] && (CNT_W'(i) < count_r)) begin
        found     = 1'b1;
        found_pos = ole_pkg::POS_W'(i + 1);
      end
    end
  end

  // Single read port into the chain: delete target, or list cursor
  assign rd_idx = (state_r == ole_pkg::S_LIST) ? list_idx_r : op_idx;

  // Operation decode for an incoming transaction
  always_comb begin
    cmd        = '0;
    cmd.value  = in_value;
    op_idx     = '0;
    dec_status = ole_pkg::STAT_OK;
    dec_value  = '0;
    dec_fpos   = '0;
    dec_last   = 1'b1;
    dec_list   = 1'b0;
    case (ole_pkg::mode_t'(in_mode))
      ole_pkg::MODE_INS_FRONT, ole_pkg::MODE_INS_BACK, ole_pkg::MODE_INS_POS: begin
        if (ole_pkg::mode_t'(in_mode) == ole_pkg::MODE_INS_BACK) begin
          op_idx = IDX_W'(count_r);
        end else if (ole_pkg::mode_t'(in_mode) == ole_pkg::MODE_INS_POS) begin
          op_idx = IDX_W'(in_position - ole_pkg::POS_W'(1));
        end
        if (is_full) begin
          dec_status = ole_pkg::STAT_FULL;
        end else if ((ole_pkg::mode_t'(in_mode) == ole_pkg::MODE_INS_POS) &&
                     ((pos_e == '0) || (pos_e > cnt_e + PW'(1)))) begin
          dec_status = ole_pkg::STAT_BADPOS;
        end else begin
          cmd.ins = in_acc;
        end
      end
      ole_pkg::MODE_DEL_FRONT, ole_pkg::MODE_DEL_BACK, ole_pkg::MODE_DEL_POS: begin
        if (ole_pkg::mode_t'(in_mode) == ole_pkg::MODE_DEL_BACK) begin
          op_idx = IDX_W'(count_r - CNT_W'(1));
        end else if (ole_pkg::mode_t'(in_mode) == ole_pkg::MODE_DEL_POS) begin
          op_idx = IDX_W'(in_position - ole_pkg::POS_W'(1));
        end
        if (is_empty) begin
          dec_status = ole_pkg::STAT_EMPTY;
        end else if ((ole_pkg::mode_t'(in_mode) == ole_pkg::MODE_DEL_POS) &&
                     ((pos_e == '0) || (pos_e > cnt_e))) begin
          dec_status = ole_pkg::STAT_BADPOS;
        end else begin
          cmd.del   = in_acc;
          dec_value = cell_data[rd_idx];
        end
      end
      ole_pkg::MODE_LIST: begin
        if (is_empty) begin
          dec_status = ole_pkg::STAT_EMPTY;
        end else begin
          dec_value = cell_data[rd_idx];
          dec_last  = (count_r == CNT_W'(1));
          dec_list  = !dec_last;
        end
      end
      ole_pkg::MODE_SEARCH: begin
        if (found) begin
          dec_fpos = found_pos;
        end else begin
          dec_status = ole_pkg::STAT_NOTFOUND;
        end
      end
      default: begin
        dec_status = ole_pkg::STAT_OK;
      end
    endcase
  end

  // Next state, entry count and list cursor
  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    list_idx_nxt = list_idx_r;
    case (state_r)
      ole_pkg::S_IDLE: begin
        if (cmd.ins) begin
          count_nxt = count_r + CNT_W'(1);
        end else if (cmd.del) begin
          count_nxt = count_r - CNT_W'(1);
        end
        if (in_acc && dec_list) begin
          state_nxt    = ole_pkg::S_LIST;
          list_idx_nxt = IDX_W'(1);
        end
      end
      ole_pkg::S_LIST: begin
        if (out_free) begin
          if (list_end) begin
            state_nxt = ole_pkg::S_IDLE;
          end else begin
            list_idx_nxt = list_idx_r + IDX_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ole_pkg::S_IDLE;
      end
    endcase
  end

  // Output register loads
  always_comb begin
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_fpos_nxt   = out_fpos_r;
    out_last_nxt   = out_last_r;
    case (state_r)
      ole_pkg::S_IDLE: begin
        if (in_acc) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = dec_status;
          out_value_nxt  = dec_value;
          out_fpos_nxt   = dec_fpos;
          out_last_nxt   = dec_last;
        end
      end
      ole_pkg::S_LIST: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ole_pkg::STAT_OK;
          out_value_nxt  = cell_data[rd_idx];
          out_fpos_nxt   = '0;
          out_last_nxt   = list_end;
        end
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ole_pkg::S_IDLE;
      count_r     <= '0;
      list_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      list_idx_r  <= list_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_fpos_r   <= out_fpos_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_value          = out_value_r;
  assign out_found_position = out_fpos_r;
  assign out_last           = out_last_r;

  // Checks
  `OLE_ASSERT_NOW(a_count_bound, 1'b1, count_r <= FULL_CNT, "entry count above depth")
  `OLE_ASSERT_NOW(a_list_frozen, state_r == ole_pkg::S_LIST, !(cmd.ins || cmd.del),
    "list changed during a listing run")
  `OLE_ASSERT_NOW(a_cursor_live, state_r == ole_pkg::S_LIST,
    CNT_W'(list_idx_r) < count_r, "list cursor beyond live entries")
  `OLE_ASSERT_NEXT(a_ins_count, cmd.ins, count_r == $past(count_r) + CNT_W'(1),
    "insert did not grow the list")
  `OLE_ASSERT_NEXT(a_del_count, cmd.del, count_r == $past(count_r) - CNT_W'(1),
    "delete did not shrink the list")

endmodule

`default_nettype wire

[tb/ordered_list_engine_tb.sv]
`timescale 1ns / 1ps

module ordered_list_engine_tb;

  localparam int LIST_DEPTH  = ole_pkg::DEFAULT_LIST_DEPTH;
  localparam int RANDOM_OPS  = 130;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT  = 20;
  localparam int PRINT_CAP   = 50;

  // Bias of the random op generator
  localparam int BIAS_FILL  = 0;
  localparam int BIAS_DRAIN = 1;
  localparam int BIAS_MIXED = 2;

  typedef struct {
    ole_pkg::mode_t             mode;
    logic [ole_pkg::POS_W-1:0]  position;
    logic [ole_pkg::DATA_W-1:0] value;
    logic [ole_pkg::DATA_W-1:0] key;
  } list_op_t;

  typedef struct packed {
    ole_pkg::status_t           status;
    logic [ole_pkg::DATA_W-1:0] value;
    logic [ole_pkg::POS_W-1:0]  found_pos;
    logic                       last;
  } list_reply_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [ole_pkg::MODE_W-1:0]   in_mode = '0;
  logic [ole_pkg::DATA_W-1:0]   in_value = '0;
  logic [ole_pkg::POS_W-1:0]    in_position = '0;
  logic [ole_pkg::DATA_W-1:0]   in_search_key = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [ole_pkg::STATUS_W-1:0] out_status;
  logic [ole_pkg::DATA_W-1:0]   out_value;
  logic [ole_pkg::POS_W-1:0]    out_found_position;
  logic                         out_last;

  ordered_list_engine #(
    .LIST_DEPTH(LIST_DEPTH)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_mode            (in_mode),
    .in_value           (in_value),
    .in_position        (in_position),
    .in_search_key      (in_search_key),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_value          (out_value),
    .out_found_position (out_found_position),
    .out_last           (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  list_op_t    pending_ops[$];
  list_reply_t awaited_replies[$];
  list_op_t    op_on_bus;
  list_reply_t got_reply;
  list_reply_t want_reply;

  // Shadow list, updated as each op is accepted
  logic [ole_pkg::DATA_W-1:0] shadow_vals [LIST_DEPTH];
  int                         shadow_len = 0;

  // Length as seen by the generator, so positions can be aimed at valid slots
  int                         gen_len = 0;
  logic [ole_pkg::DATA_W-1:0] value_pool [8];

  int cycle_count    = 0;
  int mismatch_count = 0;
  int accepted_ops   = 0;
  int total_ops      = 0;
  int random_ops     = 0;
  int burst_left     = 0;
  int idle_left      = 0;
  int rx_mode        = 0;
  int rx_stall_left  = 0;

  task automatic report_mismatch(input string what);
    mismatch_count++;
    // keep the log bounded if everything goes wrong
    if (mismatch_count <= PRINT_CAP)
      $display("[cycle %0d] MISMATCH: %s", cycle_count, what);
  endtask

  task automatic compare_field(input string name, input logic [ole_pkg::DATA_W-1:0] got,
                               input logic [ole_pkg::DATA_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%08h, want 0x%08h", name, got, want));
  endtask

  function automatic void push_reply(ole_pkg::status_t st, logic [ole_pkg::DATA_W-1:0] v,
                                     logic [ole_pkg::POS_W-1:0] fp, logic lst);
    list_reply_t r;
    r.status    = st;
    r.value     = v;
    r.found_pos = fp;
    r.last      = lst;
    awaited_replies.push_back(r);
  endfunction

  // Apply one op to the shadow list and queue the replies it should produce
  function automatic void predict_list_op(list_op_t op);
    int idx;
    bit hit;
    logic [ole_pkg::DATA_W-1:0] removed;
    idx = 0;
    hit = 1'b0;
    case (op.mode)
      ole_pkg::MODE_INS_FRONT, ole_pkg::MODE_INS_BACK, ole_pkg::MODE_INS_POS: begin
        if (shadow_len >= LIST_DEPTH) begin
          push_reply(ole_pkg::STAT_FULL, '0, '0, 1'b1);
        end else if (op.mode == ole_pkg::MODE_INS_POS &&
                     (op.position == 0 || op.position > shadow_len + 1)) begin
          push_reply(ole_pkg::STAT_BADPOS, '0, '0, 1'b1);
        end else begin
          if (op.mode == ole_pkg::MODE_INS_BACK) idx = shadow_len;
          else if (op.mode == ole_pkg::MODE_INS_POS) idx = op.position - 1;
          for (int i = shadow_len; i > idx; i--) shadow_vals[i] = shadow_vals[i-1];
          shadow_vals[idx] = op.value;
          shadow_len++;
          push_reply(ole_pkg::STAT_OK, '0, '0, 1'b1);
        end
      end
      ole_pkg::MODE_DEL_FRONT, ole_pkg::MODE_DEL_BACK, ole_pkg::MODE_DEL_POS: begin
        if (shadow_len == 0) begin
          push_reply(ole_pkg::STAT_EMPTY, '0, '0, 1'b1);
        end else if (op.mode == ole_pkg::MODE_DEL_POS &&
                     (op.position == 0 || op.position > shadow_len)) begin
          push_reply(ole_pkg::STAT_BADPOS, '0, '0, 1'b1);
        end else begin
          if (op.mode == ole_pkg::MODE_DEL_BACK) idx = shadow_len - 1;
          else if (op.mode == ole_pkg::MODE_DEL_POS) idx = op.position - 1;
          removed = shadow_vals[idx];
          for (int i = idx; i + 1 < shadow_len; i++) shadow_vals[i] = shadow_vals[i+1];
          shadow_len--;
          push_reply(ole_pkg::STAT_OK, removed, '0, 1'b1);
        end
      end
      ole_pkg::MODE_LIST: begin
        if (shadow_len == 0) begin
          push_reply(ole_pkg::STAT_EMPTY, '0, '0, 1'b1);
        end else begin
          for (int i = 0; i < shadow_len; i++)
            push_reply(ole_pkg::STAT_OK, shadow_vals[i], '0, (i + 1 == shadow_len));
        end
      end
      default: begin
        // search: first match wins
        for (int i = 0; i < shadow_len; i++) begin
          if (!hit && shadow_vals[i] == op.key) begin
            hit = 1'b1;
            push_reply(ole_pkg::STAT_OK, '0, ole_pkg::POS_W'(i + 1), 1'b1);
          end
        end
        if (!hit) push_reply(ole_pkg::STAT_NOTFOUND, '0, '0, 1'b1);
      end
    endcase
  endfunction

  // Queue an op and track the list length it leaves behind
  task automatic add_op(input ole_pkg::mode_t m, input logic [ole_pkg::POS_W-1:0] p,
                        input logic [ole_pkg::DATA_W-1:0] v,
                        input logic [ole_pkg::DATA_W-1:0] k);
    list_op_t op;
    op.mode     = m;
    op.position = p;
    op.value    = v;
    op.key      = k;
    pending_ops.push_back(op);
    case (m)
      ole_pkg::MODE_INS_FRONT, ole_pkg::MODE_INS_BACK, ole_pkg::MODE_INS_POS: begin
        if (gen_len < LIST_DEPTH &&
            (m != ole_pkg::MODE_INS_POS || (p >= 1 && p <= gen_len + 1)))
          gen_len++;
      end
      ole_pkg::MODE_DEL_FRONT, ole_pkg::MODE_DEL_BACK, ole_pkg::MODE_DEL_POS: begin
        if (gen_len > 0 && (m != ole_pkg::MODE_DEL_POS || (p >= 1 && p <= gen_len)))
          gen_len--;
      end
      default: ;
    endcase
  endtask

  // Pool values give search hits and duplicates; one case gives sign-bit corner patterns, the rest is full-range
  function automatic logic [ole_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return value_pool[$urandom_range(0, 7)];
      4:          return {1'($urandom_range(0, 1)),
                          {(ole_pkg::DATA_W-1){$urandom_range(0, 1) == 1}}};
      default:    return $urandom;
    endcase
  endfunction

  task automatic add_random_op(input int bias);
    int roll;
    ole_pkg::mode_t m;
    logic [ole_pkg::POS_W-1:0] p;
    roll = $urandom_range(0, 99);
    if (bias == BIAS_MIXED) m = ole_pkg::mode_t'($urandom_range(0, 7));
    else if (roll < 80) m = ole_pkg::mode_t'(bias == BIAS_FILL ? $urandom_range(0, 2)
                                                               : $urandom_range(3, 5));
    else if (roll < 90) m = ole_pkg::MODE_SEARCH;
    else if (roll < 95) m = ole_pkg::MODE_LIST;
    else m = ole_pkg::mode_t'(bias == BIAS_FILL ? $urandom_range(3, 5)
                                                : $urandom_range(0, 2));

    // mostly aim positions at valid slots, sometimes anywhere
    p = ole_pkg::POS_W'($urandom_range(0, 31));
    if ($urandom_range(0, 99) < 85) begin
      if (m == ole_pkg::MODE_INS_POS)
        p = ole_pkg::POS_W'($urandom_range(1, gen_len + 1));
      else if (m == ole_pkg::MODE_DEL_POS && gen_len > 0)
        p = ole_pkg::POS_W'($urandom_range(1, gen_len));
    end
    add_op(m, p, pick_value(), pick_value());
    random_ops++;
  endtask

  // Sender: bursts of random length with random gaps between them
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_list_op(op_on_bus);
        accepted_ops++;
      end
      if (!in_valid || in_ready) begin
        if (idle_left > 0) begin
          idle_left--;
          in_valid <= 1'b0;
        end else if (pending_ops.size() != 0) begin
          op_on_bus = pending_ops.pop_front();
          in_mode       <= op_on_bus.mode;
          in_position   <= op_on_bus.position;
          in_value      <= op_on_bus.value;
          in_search_key <= op_on_bus.key;
          in_valid      <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 8);
            idle_left  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: switches between randomly chosen stall patterns
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got_reply = {ole_pkg::status_t'(out_status), out_value, out_found_position,
                     out_last};
        if (awaited_replies.size() == 0) begin
          report_mismatch($sformatf("unexpected transaction, status %0d value 0x%08h",
                                    out_status, out_value));
        end else begin
          want_reply = awaited_replies.pop_front();
          compare_field("status", ole_pkg::DATA_W'(got_reply.status),
                        ole_pkg::DATA_W'(want_reply.status));
          compare_field("value", got_reply.value, want_reply.value);
          compare_field("found_position", ole_pkg::DATA_W'(got_reply.found_pos),
                        ole_pkg::DATA_W'(want_reply.found_pos));
          compare_field("last", ole_pkg::DATA_W'(got_reply.last),
                        ole_pkg::DATA_W'(want_reply.last));
        end
      end
      if (cycle_count % 48 == 0) rx_mode = $urandom_range(0, 3);
      case (rx_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= (cycle_count % 4 == 0);
        default: begin
          if (rx_stall_left > 0) begin
            rx_stall_left--;
            out_ready <= 1'b0;
          end else begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 5) == 0) rx_stall_left = $urandom_range(2, 8);
          end
        end
      endcase
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7FFF_FFFF;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hFFFF_FFFF;
    for (int i = 4; i < 8; i++) value_pool[i] = $urandom;

    // Directed: ops on the empty list
    add_op(ole_pkg::MODE_LIST, '0, '0, '0);
    add_op(ole_pkg::MODE_DEL_FRONT, '0, '0, '0);
    add_op(ole_pkg::MODE_DEL_BACK, '0, '0, '0);
    add_op(ole_pkg::MODE_DEL_POS, 5'd1, '0, '0);
    add_op(ole_pkg::MODE_SEARCH, '0, '0, 32'h0000_0000);
    add_op(ole_pkg::MODE_INS_POS, 5'd0, 32'h1111_1111, '0);
    add_op(ole_pkg::MODE_INS_POS, 5'd2, 32'h2222_2222, '0);
    // Directed: build a small list with extreme values and a duplicate
    add_op(ole_pkg::MODE_INS_POS, 5'd1, 32'h8000_0000, '0);
    add_op(ole_pkg::MODE_INS_FRONT, '0, 32'h7FFF_FFFF, '0);
    add_op(ole_pkg::MODE_INS_BACK, '0, 32'hFFFF_FFFF, '0);
    add_op(ole_pkg::MODE_INS_POS, 5'd4, 32'h0000_0000, '0);
    add_op(ole_pkg::MODE_INS_POS, 5'd2, 32'h8000_0000, '0);
    add_op(ole_pkg::MODE_SEARCH, '0, '0, 32'h8000_0000);
    add_op(ole_pkg::MODE_SEARCH, '0, '0, 32'h1234_5678);
    add_op(ole_pkg::MODE_LIST, '0, '0, '0);
    // Directed: out-of-range positions on a non-empty list
    add_op(ole_pkg::MODE_DEL_POS, 5'd0, '0, '0);
    add_op(ole_pkg::MODE_DEL_POS, 5'd31, '0, '0);
    add_op(ole_pkg::MODE_INS_POS, 5'd31, 32'h3333_3333, '0);
    add_op(ole_pkg::MODE_INS_POS, 5'd0, 32'h4444_4444, '0);
    // Directed: delete from each end and the last position
    add_op(ole_pkg::MODE_DEL_POS, 5'd5, '0, '0);
    add_op(ole_pkg::MODE_DEL_BACK, '0, '0, '0);
    add_op(ole_pkg::MODE_DEL_FRONT, '0, '0, '0);
    add_op(ole_pkg::MODE_DEL_POS, 5'd2, '0, '0);

    // Random: fill to full, overflow, drain to empty, underflow, then mixed noise
    while (random_ops < RANDOM_OPS) begin
      while (gen_len < LIST_DEPTH) add_random_op(BIAS_FILL);
      add_op(ole_pkg::mode_t'($urandom_range(0, 2)), ole_pkg::POS_W'($urandom_range(0, 31)),
             pick_value(), '0);
      add_op(ole_pkg::mode_t'($urandom_range(0, 2)), ole_pkg::POS_W'($urandom_range(0, 31)),
             pick_value(), '0);
      add_op(ole_pkg::MODE_LIST, ole_pkg::POS_W'($urandom_range(0, 31)), pick_value(),
             pick_value());
      add_op(ole_pkg::MODE_SEARCH, ole_pkg::POS_W'($urandom_range(0, 31)), pick_value(),
             pick_value());
      while (gen_len > 0) add_random_op(BIAS_DRAIN);
      add_op(ole_pkg::mode_t'($urandom_range(3, 5)), ole_pkg::POS_W'($urandom_range(0, 31)),
             pick_value(), '0);
      add_op(ole_pkg::MODE_LIST, ole_pkg::POS_W'($urandom_range(0, 31)), pick_value(),
             pick_value());
      add_op(ole_pkg::MODE_SEARCH, ole_pkg::POS_W'($urandom_range(0, 31)), pick_value(),
             pick_value());
      random_ops += 7;
      repeat (15) add_random_op(BIAS_MIXED);
    end
    total_ops = pending_ops.size();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted_ops < total_ops) @(posedge clk);
    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/ole_pkg.sv
rtl/ole_cell.sv
rtl/ordered_list_engine.sv
tb/ordered_list_engine_tb.sv
